>>> sv/skvenv_pkg.sv
package skvenv_pkg;

  localparam int NUM_ENVIRONMENTS_DEF = 4;
  localparam int ENTRIES_PER_ENV_DEF  = 16;
  localparam int KEY_WIDTH_DEF        = 32;
  localparam int VALUE_WIDTH          = 64;
  localparam int MAX_RESULTS          = 16;
  localparam int IN_DATA_WIDTH        = 112;
  localparam int OUT_DATA_WIDTH       = 112;

  localparam logic [2:0] ACT_GET   = 3'd0;
  localparam logic [2:0] ACT_SET   = 3'd1;
  localparam logic [2:0] ACT_UNSET = 3'd2;
  localparam logic [2:0] ACT_CLONE = 3'd3;
  localparam logic [2:0] ACT_DUMP  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_LIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_FREE  = 2'd3;

  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_UPDATE,
    CELL_INSERT,
    CELL_ERASE,
    CELL_CLONE,
    CELL_LOAD_DUMP,
    CELL_SHIFT_DUMP
  } cell_op_t;

  // Compare flags that each cell registers for the addressed environment.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

>>> sv/sorted_key_value_environments_core.sv
// Sorted key/value environments.
// Input channel in_*: one action per item (get, set, unset, clone, dump).
// in_tdata from bit 0 up: action[3], env_id[2], lookup_key[32], new_value[64],
// dump_limit[6], zero fill. Result channel out_*: out_tdata from bit 0 up:
// found[1], out_key[32], out_value[64], count_words[6], new_env[2], status[2],
// zero fill; out_tlast marks the last result of an action.
// Entries live in a row of cells, one per table slot, each holding that slot
// for every environment. An action is taken when the core is idle, the cells
// compare the key in the next cycle, and in the cycle after that the insert
// or erase is applied to all cells at once as a neighbor shift; an update or
// clone writes within each cell. A single result is valid after the compare
// and execute states, and the next item is taken only after that result is
// accepted. A dump gives one pair per cycle, while out_tready is high, from
// the head of the cell row. While a result waits on out_tready it holds, and
// no new item is taken. After reset only environment 0 is live, and it is empty.
module sorted_key_value_environments_core #(
  parameter int NUM_ENVIRONMENTS = skvenv_pkg::NUM_ENVIRONMENTS_DEF,
  parameter int ENTRIES_PER_ENV  = skvenv_pkg::ENTRIES_PER_ENV_DEF,
  parameter int KEY_WIDTH        = skvenv_pkg::KEY_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // action, env_id, lookup_key, new_value, dump_limit (from bit 0)
  input  logic [skvenv_pkg::IN_DATA_WIDTH-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // found, out_key, out_value, count_words, new_env, status (from bit 0)
  output logic [skvenv_pkg::OUT_DATA_WIDTH-1:0] out_tdata,
  output logic                                  out_tlast
);

  localparam int EW = $clog2(NUM_ENVIRONMENTS+1);
  localparam int IW = (NUM_ENVIRONMENTS > 1) ? $clog2(NUM_ENVIRONMENTS) : 1;
  localparam int CW = $clog2(ENTRIES_PER_ENV+1);
  localparam int VW = skvenv_pkg::VALUE_WIDTH;
  localparam int E  = ENTRIES_PER_ENV;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_EXEC = 5'b00100,
    S_OUT  = 5'b01000,
    S_DUMP = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]           act_r;
  logic [EW-1:0]        env_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [VW-1:0]        val_r;
  logic [5:0]           limit_r;
  logic [EW-1:0]        live_r, live_nxt;
  logic [CW-1:0]        cnt_r [NUM_ENVIRONMENTS];
  logic [4:0]           rem_r, rem_nxt;

  logic                 o_found_r;
  logic [VW-1:0]        o_val_r;
  logic [5:0]           o_cnt_r;
  logic [1:0]           o_new_r;
  logic [1:0]           o_st_r;

  logic [7:0]  env8;
  logic [63:0] key64;
  logic        in_acc, out_acc;
  logic        live_ok, hit;
  logic [CW-1:0] cnt;
  logic [VW-1:0] hit_val;
  skvenv_pkg::cell_op_t op;
  logic [IW-1:0] env_idx;
  logic [IW-1:0] dst;

  skvenv_pkg::cell_flags_t    flg  [E];
  logic [KEY_WIDTH-1:0]       ck   [E];
  logic [VW-1:0]              cv   [E];
  logic [KEY_WIDTH-1:0]       dk   [E];
  logic [VW-1:0]              dv   [E];

  assign in_tready = state_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT) || (state_r == S_DUMP);
  assign out_acc   = out_tvalid && out_tready;
  assign env8      = {6'b0, in_tdata[4:3]};
  assign key64     = {32'b0, in_tdata[36:5]};
  assign live_ok   = int'(env_r) < int'(live_r) && int'(env_r) < NUM_ENVIRONMENTS;
  assign env_idx   = env_r[IW-1:0];
  assign cnt       = live_ok ? cnt_r[env_idx] : '0;
  assign dst       = live_r[IW-1:0];

  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int i = 0; i < E; i++) begin
      hit     = hit | flg[i].eq;
      hit_val = hit_val | (flg[i].eq ? cv[i] : '0);
    end
  end

  genvar g;
  generate
    for (g = 0; g < E; g++) begin : g_cell
      skvenv_cell #(
        .NUM_ENVIRONMENTS(NUM_ENVIRONMENTS),
        .ENTRIES_PER_ENV (ENTRIES_PER_ENV),
        .KEY_WIDTH       (KEY_WIDTH),
        .IDX             (g)
      ) u_cell (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .env             (env_idx),
        .dst_env         (dst),
        .cnt             (cnt),
        .key             (key_r),
        .value           (val_r),
        .left_lt         (g == 0 ? 1'b1 : flg[(g == 0) ? 0 : g-1].lt),
        .left_key        (ck[(g == 0) ? 0 : g-1]),
        .left_value      (cv[(g == 0) ? 0 : g-1]),
        .right_key       (ck[(g == E-1) ? g : g+1]),
        .right_value     (cv[(g == E-1) ? g : g+1]),
        .right_dump_key  (dk[(g == E-1) ? g : g+1]),
        .right_dump_value(dv[(g == E-1) ? g : g+1]),
        .flags           (flg[g]),
        .cur_key         (ck[g]),
        .cur_value       (cv[g]),
        .dump_key        (dk[g]),
        .dump_value      (dv[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_tdata[2:0];
      env_r   <= env8[EW-1:0];
      key_r   <= key64[KEY_WIDTH-1:0];
      val_r   <= in_tdata[100:37];
      limit_r <= in_tdata[106:101];
    end
  end

  // Decision cycle: pick the cell operation and the result fields.
  logic          n_found;
  logic [VW-1:0] n_val;
  logic [CW-1:0] n_cnt;
  logic [1:0]    n_new, n_st;
  logic          cnt_we, cnt_dst;
  int            n_dump;

  always_comb begin
    op        = skvenv_pkg::CELL_NONE;
    n_found   = 1'b0;
    n_val     = '0;
    n_cnt     = cnt;
    n_new     = 2'd0;
    n_st      = skvenv_pkg::ST_OK;
    cnt_we    = 1'b0;
    cnt_dst   = 1'b0;
    live_nxt  = live_r;
    state_nxt = state_r;
    rem_nxt   = rem_r;
    n_dump    = int'(limit_r[5:1]);
    if (n_dump > int'(cnt)) n_dump = int'(cnt);
    if (n_dump > skvenv_pkg::MAX_RESULTS) n_dump = skvenv_pkg::MAX_RESULTS;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_OUT;
        if (!live_ok) begin
          n_st = skvenv_pkg::ST_NOT_LIVE;
        end else begin
          unique case (act_r)
            skvenv_pkg::ACT_GET: begin
              n_found = hit;
              n_val   = hit_val;
            end
            skvenv_pkg::ACT_SET: begin
              if (hit) begin
                op = skvenv_pkg::CELL_UPDATE;
              end else if (int'(cnt) >= E) begin
                n_st = skvenv_pkg::ST_FULL;
              end else begin
                op     = skvenv_pkg::CELL_INSERT;
                n_cnt  = cnt + 1'b1;
                cnt_we = 1'b1;
              end
            end
            skvenv_pkg::ACT_UNSET: begin
              n_found = hit;
              if (hit) begin
                op     = skvenv_pkg::CELL_ERASE;
                n_cnt  = cnt - 1'b1;
                cnt_we = 1'b1;
              end
            end
            skvenv_pkg::ACT_CLONE: begin
              if (int'(live_r) >= NUM_ENVIRONMENTS) begin
                n_st = skvenv_pkg::ST_NO_FREE;
              end else begin
                op       = skvenv_pkg::CELL_CLONE;
                cnt_we   = 1'b1;
                cnt_dst  = 1'b1;
                live_nxt = live_r + 1'b1;
                n_new    = 2'(dst);
              end
            end
            skvenv_pkg::ACT_DUMP: begin
              if (n_dump != 0) begin
                op        = skvenv_pkg::CELL_LOAD_DUMP;
                rem_nxt   = 5'(n_dump);
                state_nxt = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OUT: if (out_acc) state_nxt = S_IDLE;
      S_DUMP: begin
        if (out_acc) begin
          op      = skvenv_pkg::CELL_SHIFT_DUMP;
          rem_nxt = rem_r - 1'b1;
          if (rem_r == 5'd1) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r  <= EW'(1);
      rem_r   <= '0;
      for (int i = 0; i < NUM_ENVIRONMENTS; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      rem_r   <= rem_nxt;
      if (cnt_we) begin
        if (cnt_dst) cnt_r[dst] <= n_cnt;
        else         cnt_r[env_idx] <= n_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      o_found_r <= n_found;
      o_val_r   <= n_val;
      o_cnt_r   <= 6'({n_cnt, 1'b0});
      o_new_r   <= n_new;
      o_st_r    <= n_st;
    end
  end

  logic [63:0] dk64;
  assign dk64 = 64'(dk[0]);

  always_comb begin
    out_tdata = '0;
    if (state_r == S_DUMP) begin
      out_tdata[0]      = 1'b1;
      out_tdata[32:1]   = dk64[31:0];
      out_tdata[96:33]  = dv[0];
      out_tdata[102:97] = o_cnt_r;
      out_tlast         = rem_r == 5'd1;
    end else begin
      out_tdata[0]       = o_found_r;
      out_tdata[96:33]   = o_val_r;
      out_tdata[102:97]  = o_cnt_r;
      out_tdata[104:103] = o_new_r;
      out_tdata[106:105] = o_st_r;
      out_tlast          = 1'b1;
    end
  end

endmodule

>>> sv/skvenv_cell.sv
module skvenv_cell #(
  parameter int NUM_ENVIRONMENTS = skvenv_pkg::NUM_ENVIRONMENTS_DEF,
  parameter int ENTRIES_PER_ENV  = skvenv_pkg::ENTRIES_PER_ENV_DEF,
  parameter int KEY_WIDTH        = skvenv_pkg::KEY_WIDTH_DEF,
  parameter int IDX              = 0,
  localparam int IW = (NUM_ENVIRONMENTS > 1) ? $clog2(NUM_ENVIRONMENTS) : 1
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  skvenv_pkg::cell_op_t                    op,
  input  logic [IW-1:0]                           env,
  input  logic [IW-1:0]                           dst_env,
  input  logic [$clog2(ENTRIES_PER_ENV+1)-1:0]    cnt,
  input  logic [KEY_WIDTH-1:0]                    key,
  input  logic [skvenv_pkg::VALUE_WIDTH-1:0]      value,
  input  logic                                    left_lt,
  input  logic [KEY_WIDTH-1:0]                    left_key,
  input  logic [skvenv_pkg::VALUE_WIDTH-1:0]      left_value,
  input  logic [KEY_WIDTH-1:0]                    right_key,
  input  logic [skvenv_pkg::VALUE_WIDTH-1:0]      right_value,
  input  logic [KEY_WIDTH-1:0]                    right_dump_key,
  input  logic [skvenv_pkg::VALUE_WIDTH-1:0]      right_dump_value,
  output skvenv_pkg::cell_flags_t                 flags,
  output logic [KEY_WIDTH-1:0]                    cur_key,
  output logic [skvenv_pkg::VALUE_WIDTH-1:0]      cur_value,
  output logic [KEY_WIDTH-1:0]                    dump_key,
  output logic [skvenv_pkg::VALUE_WIDTH-1:0]      dump_value
);

  localparam int CW = $clog2(ENTRIES_PER_ENV+1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [KEY_WIDTH-1:0]               key_r [NUM_ENVIRONMENTS];
  logic [skvenv_pkg::VALUE_WIDTH-1:0] val_r [NUM_ENVIRONMENTS];
  skvenv_pkg::cell_flags_t            flags_r;
  logic [KEY_WIDTH-1:0]               dkey_r;
  logic [skvenv_pkg::VALUE_WIDTH-1:0] dval_r;
  logic                               occ;

  assign cur_key    = key_r[env];
  assign cur_value  = val_r[env];
  assign occ        = MY_IDX < cnt;
  assign flags      = flags_r;
  assign dump_key   = dkey_r;
  assign dump_value = dval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r.lt <= occ && (cur_key < key);
      flags_r.eq <= occ && (cur_key == key);
    end
  end

  // Sorted order makes the lt flags a prefix: cells at or past the insert
  // point shift right, and the one whose left neighbor is still below takes the key.
  always_ff @(posedge clk) begin
    unique case (op)
      skvenv_pkg::CELL_UPDATE: begin
        if (flags_r.eq) val_r[env] <= value;
      end
      skvenv_pkg::CELL_INSERT: begin
        if (!flags_r.lt) begin
          if (left_lt) begin
            key_r[env] <= key;
            val_r[env] <= value;
          end else begin
            key_r[env] <= left_key;
            val_r[env] <= left_value;
          end
        end
      end
      skvenv_pkg::CELL_ERASE: begin
        if (!flags_r.lt) begin
          key_r[env] <= right_key;
          val_r[env] <= right_value;
        end
      end
      skvenv_pkg::CELL_CLONE: begin
        key_r[dst_env] <= cur_key;
        val_r[dst_env] <= cur_value;
      end
      skvenv_pkg::CELL_LOAD_DUMP: begin
        dkey_r <= cur_key;
        dval_r <= cur_value;
      end
      skvenv_pkg::CELL_SHIFT_DUMP: begin
        dkey_r <= right_dump_key;
        dval_r <= right_dump_value;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/skvenv_checker.sv
module skvenv_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input open while a result is pending");

  a_not_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[106:105] == skvenv_pkg::ST_NOT_LIVE
      |-> out_tdata[102:97] == 6'd0 && out_tlast && !out_tdata[0])
    else $error("bad result for an environment that is not live");

endmodule

bind sorted_key_value_environments_core skvenv_checker u_skvenv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
